>>> src/rcct_pkg.sv
// shared types and constants for the rectangle claim conflict table
`default_nettype none

package rcct_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int ID_BITS     = 16;
    localparam int COORD_W     = 32;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int HELD_W      = 6;
    localparam int STATUS_W    = 3;

    localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_CONFLICT = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_HELD = 3'd4;

    localparam logic REQ_CLAIM   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic [ID_BITS-1:0]        owner;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic owner_hit;
        logic overlap;
    } cmp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE
    } state_t;

endpackage

`default_nettype wire

>>> src/rcct_overlap.sv
// owner match and positive-area overlap test of the request against one stored entry
`default_nettype none

module rcct_overlap
    import rcct_pkg::*;
(
    input  wire logic [ID_BITS-1:0] req_id,
    input  wire logic [COORD_W-1:0] req_x_lo,
    input  wire logic [COORD_W-1:0] req_y_lo,
    input  wire logic [COORD_W-1:0] req_x_hi,
    input  wire logic [COORD_W-1:0] req_y_hi,
    input  wire entry_t             entry,
    output cmp_t                    result
);

    logic apart_x;
    logic apart_y;

    // touching edges count as apart
    assign apart_x = ($signed(req_x_hi) <= $signed(entry.left)) ||
                     ($signed(entry.right) <= $signed(req_x_lo));
    assign apart_y = ($signed(req_y_hi) <= $signed(entry.bottom)) ||
                     ($signed(entry.top) <= $signed(req_y_lo));

    assign result.owner_hit = (entry.owner == req_id);
    assign result.overlap   = !(apart_x || apart_y);

endmodule

`default_nettype wire

>>> src/rectangle_claim_conflict_table.sv
// top level of the rectangle claim conflict table: slot memory, scan sequencer, decision
// one transaction at a time; the next start is taken in the result strobe cycle
// the scan reads one slot of the table memory (separate read and write addresses) per
// cycle (32 reads); S_LAST does the last compare, S_DECIDE the decision and write-back
// reset clears all slot valid bits and the held count at once; the memory itself is not
// cleared, entries are only looked at while their valid bit is set
`default_nettype none

module rectangle_claim_conflict_table
    import rcct_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire logic                req_type,
    input  wire logic [15:0]         owner_id,
    input  wire logic signed [31:0]  box_x_lo,
    input  wire logic signed [31:0]  box_y_lo,
    input  wire logic signed [31:0]  box_x_hi,
    input  wire logic signed [31:0]  box_y_hi,
    output      logic                done,
    output      logic [STATUS_W-1:0] status,
    output      logic [HELD_W-1:0]   held_count
);

    // slot table: boxes and owners in memory, valid bits in flops
    logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    entry_t             wr_entry;

    // captured transaction
    logic               req_type_reg;
    logic [ID_BITS-1:0] req_id_reg;
    logic [COORD_W-1:0] req_x_lo_reg;
    logic [COORD_W-1:0] req_y_lo_reg;
    logic [COORD_W-1:0] req_x_hi_reg;
    logic [COORD_W-1:0] req_y_hi_reg;
    logic               accept;

    // sequencer and scan accumulators
    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               conflict_reg, conflict_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  found_idx_reg, found_idx_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   held_reg, held_next;

    // result registers
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HELD_W-1:0]   count_out_reg, count_out_next;

    // lowest free slot
    logic               free_any;
    logic [SLOT_W-1:0]  free_idx;

    cmp_t               cmp;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // id bits above ID_BITS are ignored
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req_type;
            req_id_reg   <= ID_BITS'(owner_id);
            req_x_lo_reg <= box_x_lo;
            req_y_lo_reg <= box_y_lo;
            req_x_hi_reg <= box_x_hi;
            req_y_hi_reg <= box_y_hi;
        end
    end

    assign wr_entry.owner  = req_id_reg;
    assign wr_entry.left   = req_x_lo_reg;
    assign wr_entry.bottom = req_y_lo_reg;
    assign wr_entry.right  = req_x_hi_reg;
    assign wr_entry.top    = req_y_hi_reg;

    // table with separate write and read addresses: write only in the decision cycle, reads during the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[free_idx] <= wr_entry;
        end
        rd_data_reg <= mem[idx_reg];
    end

    rcct_overlap u_overlap (
        .req_id   (req_id_reg),
        .req_x_lo (req_x_lo_reg),
        .req_y_lo (req_y_lo_reg),
        .req_x_hi (req_x_hi_reg),
        .req_y_hi (req_y_hi_reg),
        .entry    (entry_t'(rd_data_reg)),
        .result   (cmp)
    );

    // priority encoder for the lowest invalid slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            conflict_reg  <= 1'b0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            valid_reg     <= '0;
            held_reg      <= '0;
            done_reg      <= 1'b0;
            status_reg    <= STAT_GRANTED;
            count_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            conflict_reg  <= conflict_next;
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
            valid_reg     <= valid_next;
            held_reg      <= held_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            count_out_reg <= count_out_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = idx_reg;
        conflict_next  = conflict_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        valid_next     = valid_reg;
        held_next      = held_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        mem_we         = 1'b0;

        // fold in the slot read in the previous cycle; own boxes never conflict
        if (cmp_vld_reg && valid_reg[cmp_idx_reg])
        begin
            if (cmp.owner_hit)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
            end
            else if (cmp.overlap)
            begin
                conflict_next = 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next    = S_SCAN;
                    idx_next      = '0;
                    conflict_next = 1'b0;
                    found_next    = 1'b0;
                end
            end
            S_SCAN:
            begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = idx_reg;
                if (idx_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                // last slot compare lands this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (req_type_reg == REQ_CLAIM)
                begin
                    // conflict first, then already held, then room check
                    priority if (conflict_reg)
                    begin
                        status_next = STAT_CONFLICT;
                    end
                    else if (found_reg)
                    begin
                        status_next = STAT_GRANTED;
                    end
                    else if (!free_any)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        held_next            = held_reg + 1'b1;
                        status_next          = STAT_GRANTED;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        valid_next[found_idx_reg] = 1'b0;
                        if (held_reg != '0)
                        begin
                            held_next = held_reg - 1'b1;
                        end
                        status_next = STAT_RELEASED;
                    end
                    else
                    begin
                        status_next = STAT_NOT_HELD;
                    end
                end
                count_out_next = HELD_W'(held_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign held_count = count_out_reg;

endmodule

`default_nettype wire

>>> src/rcct_checker.sv
// port-level checker for the rectangle claim conflict table, bound to the top level
`default_nettype none

module rcct_checker
    import rcct_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [HELD_W-1:0]   held_count
);

    logic accept;

    assign accept = start && !busy;

    // a taken transaction keeps the block busy until its result
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after transaction accepted");

    // the result never appears in the cycle right after acceptance
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !done)
        else $error("result strobe too early");

    // the strobe marks the end of the work
    a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (held_count <= HELD_W'(TABLE_SLOTS)))
        else $error("held count above table size");

    // a release that succeeds cannot leave a full table
    a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_RELEASED)) |-> (held_count < HELD_W'(TABLE_SLOTS)))
        else $error("held count not reduced by release");

endmodule

bind rectangle_claim_conflict_table rcct_checker u_rcct_checker (.*);

`default_nettype wire
